// ===== rtl/core/dpq_pkg.sv =====
// dpq_pkg: shared types and constants for the double-ended priority queue.
// Holds the request/response word structs, the cell command struct and the codes.
// No dependencies.
`default_nettype none

package dpq_pkg;

   // Sizing
   localparam int CAPACITY    = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Request word
   typedef struct packed {
      logic                  func;
      logic [DATA_WIDTH-1:0] value;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [1:0]             status;
      logic [DATA_WIDTH-1:0]  removed_value;
      logic                   nonempty;
      logic [DATA_WIDTH-1:0]  max_value;
      logic [DATA_WIDTH-1:0]  min_value;
      logic [COUNT_WIDTH-1:0] entry_count;
   } rsp_word_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                  insert;
      logic                  remove;
      logic [DATA_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/dpq_cell.sv =====
// dpq_cell: one slot of the sorted chain (largest value at the head).
// Shifts down on insert below the new value, shifts up on remove of the head.
// Depends on dpq_pkg.
`default_nettype none

module dpq_cell (
   input  wire                               clock,
   input  dpq_pkg::cell_cmd_type             cmd,
   input  wire                               valid,
   input  wire                               prev_keep,
   input  wire  [dpq_pkg::DATA_WIDTH-1:0]    prev_value,
   input  wire  [dpq_pkg::DATA_WIDTH-1:0]    next_value,
   output logic [dpq_pkg::DATA_WIDTH-1:0]    value,
   output logic                              keep
);

   logic [dpq_pkg::DATA_WIDTH-1:0] value_ff;
   logic [dpq_pkg::DATA_WIDTH-1:0] value_in;

   // Slot stays put on insert when it already holds something not below the new word
   assign keep = valid && (value_ff >= cmd.value);

   // Next slot content
   always_comb begin
      value_in = value_ff;
      if (cmd.remove) begin
         value_in = next_value;
      end else if (cmd.insert && !keep) begin
         if (prev_keep) begin
            value_in = cmd.value;
         end else begin
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_priority_queue.sv =====
// Double-ended priority queue: top level with control, fill count and the cell chain.
// Reports largest and smallest stored value after every operation.
// Depends on dpq_pkg and dpq_cell.
//
// Usage:
//   req channel (req_valid/req_stall/req_word): one word is an insert of
//   req_word.value (func 0) or a removal of the current maximum (func 1).
//   rsp channel (rsp_valid/rsp_stall/rsp_word): exactly one response word per
//   request: status, removed value, nonempty flag, max, min and entry count.
//   Values live in a chain of CAPACITY cells kept sorted, largest at the head;
//   an insert or remove reshapes the whole chain in the cycle it is accepted.
//   The accept updates the chain, count, status and removed value; the
//   sequencer then moves to ST_REPORT and registers the response word once
//   the output register is free. req_stall stays high in ST_REPORT, so a new
//   request is taken only after the last response has been registered.
//   An insert into a full queue reports status 1 and a remove from an empty
//   queue reports status 2; neither changes the contents.
//   Reset empties the queue (count to zero) and drops any pending response.
//   While rsp_stall is high the response word holds; one further request may
//   be accepted meanwhile, and its response waits until the register frees.
`default_nettype none

module double_ended_priority_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  dpq_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output dpq_pkg::rsp_word_type  rsp_word
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_REPORT = 1'b1;

   localparam int N  = dpq_pkg::CAPACITY;
   localparam int DW = dpq_pkg::DATA_WIDTH;
   localparam int CW = dpq_pkg::COUNT_WIDTH;

   logic                  state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            status_ff, status_in;
   logic [DW-1:0]         removed_ff, removed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dpq_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  do_insert;
   logic                  do_remove;
   logic                  load;
   dpq_pkg::cell_cmd_type cmd;

   logic [DW-1:0]         cell_value [N];
   logic                  cell_keep  [N];
   logic [N-1:0]          cell_valid;
   logic [DW-1:0]         min_value;

   // Handshake and operation decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(N));
   assign empty     = (count_ff == '0);
   assign do_insert = accept && (req_word.func == dpq_pkg::FUNC_INSERT) && !full;
   assign do_remove = accept && (req_word.func == dpq_pkg::FUNC_REMOVE) && !empty;

   assign cmd.insert = do_insert;
   assign cmd.remove = do_remove;
   assign cmd.value  = req_word.value;

   // Fill count marks which cells hold live values
   generate
      for (genvar i = 0; i < N; i++) begin : g_valid
         assign cell_valid[i] = (CW'(i) < count_ff);
      end
   endgenerate

   // Sorted chain
   generate
      for (genvar i = 0; i < N; i++) begin : g_cell
         logic          prev_keep;
         logic [DW-1:0] prev_value;
         logic [DW-1:0] next_value;
         if (i == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_value = req_word.value;
         end else begin : g_body
            assign prev_keep  = cell_keep[i-1];
            assign prev_value = cell_value[i-1];
         end
         if (i == N - 1) begin : g_tail
            assign next_value = cell_value[i];
         end else begin : g_mid
            assign next_value = cell_value[i+1];
         end
         dpq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .valid      (cell_valid[i]),
            .prev_keep  (prev_keep),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (cell_value[i]),
            .keep       (cell_keep[i])
         );
      end
   endgenerate

   // Minimum: the last live cell of the chain
   always_comb begin
      min_value = '0;
      for (int i = 0; i < N; i++) begin
         if (cell_valid[i] && ((i == N - 1) || !cell_valid[(i + 1) % N])) begin
            min_value = min_value | cell_value[i];
         end
      end
   end

   // Count, status and removed word captured at accept
   always_comb begin
      count_in   = count_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      if (do_insert) begin
         count_in = count_ff + CW'(1);
      end else if (do_remove) begin
         count_in = count_ff - CW'(1);
      end
      if (accept) begin
         removed_in = '0;
         if (req_word.func == dpq_pkg::FUNC_INSERT) begin
            status_in = full ? dpq_pkg::STATUS_FULL : dpq_pkg::STATUS_DONE;
         end else if (empty) begin
            status_in = dpq_pkg::STATUS_EMPTY;
         end else begin
            status_in  = dpq_pkg::STATUS_DONE;
            removed_in = cell_value[0];
         end
      end
   end

   // Sequencer: accept, then register the response once the output is free
   assign load = (state_ff == ST_REPORT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (load) begin
         rsp_word_in.status        = status_ff;
         rsp_word_in.removed_value = removed_ff;
         rsp_word_in.nonempty      = !empty;
         rsp_word_in.max_value     = empty ? '0 : cell_value[0];
         rsp_word_in.min_value     = min_value;
         rsp_word_in.entry_count   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dpq_checker.sv =====
// dpq_checker: port-level assertions for the double-ended priority queue.
// Bound to the top level; depends on dpq_pkg.
`default_nettype none

module dpq_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input dpq_pkg::req_word_type  req_word,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input dpq_pkg::rsp_word_type  rsp_word
);

   // A stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // One request in flight: stall follows every accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in progress");

   // Nonempty flag agrees with the count, count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.nonempty == (rsp_word.entry_count != '0)) &&
                    (rsp_word.entry_count <= dpq_pkg::COUNT_WIDTH'(dpq_pkg::CAPACITY)))
      else $error("nonempty flag or count inconsistent");

   // Ordering of the reported extremes, zeros when empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.nonempty ? (rsp_word.max_value >= rsp_word.min_value)
                                       : (rsp_word.max_value == '0 &&
                                          rsp_word.min_value == '0)))
      else $error("max/min inconsistent");

   // Rejected operations remove nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != dpq_pkg::STATUS_DONE) |->
         rsp_word.removed_value == '0)
      else $error("rejected operation reported a removed value");

endmodule

bind double_ended_priority_queue dpq_checker u_dpq_checker (.*);

`default_nettype wire
